>>> sv/weighted_overlap_add_normalizer_macros.svh
// Assertion macros for the weighted overlap-add normalizer.
// Used by modules that carry concurrent checks; no other dependencies.
`ifndef WEIGHTED_OVERLAP_ADD_NORMALIZER_MACROS_SVH
`define WEIGHTED_OVERLAP_ADD_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define WOAN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WOAN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WOAN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WOAN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/woan_pkg.sv
// Shared types and constants for the weighted overlap-add normalizer.
// No dependencies; imported by every module of the block.
package woan_pkg;

    localparam int MAX_LANES   = 8;
    localparam int MAX_FRAMES  = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int LANE_W       = 3;
    localparam int FRAME_W      = 12;
    localparam int ADDR_W       = LANE_W + FRAME_W;
    localparam int DEPTH        = MAX_LANES * MAX_FRAMES;
    localparam int GAIN_W       = 16;
    localparam int ACC_W        = 40;
    localparam int WSUM_W       = 24;
    localparam int PROD_W       = SAMPLE_BITS + GAIN_W + 1;
    localparam int NUM_W        = ACC_W + 2;
    localparam int Q_W          = SAMPLE_BITS + 2;
    localparam int DIV_CNT_W    = 5;
    localparam int LANES_CFG_W  = 4;
    localparam int FRAMES_CFG_W = 13;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;

    localparam logic [1:0] MODE_ACC  = 2'd0;
    localparam logic [1:0] MODE_NORM = 2'd1;
    localparam logic [1:0] MODE_CLR  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LANES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED = 2'd2;

    localparam logic [WSUM_W-1:0]      UNITY_GAIN = 24'd32768;
    localparam logic [SAMPLE_BITS:0]   POS_LIMIT  = 17'd32767;
    localparam logic [SAMPLE_BITS:0]   NEG_LIMIT  = 17'd32768;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'h8000;

    typedef struct packed {
        logic [1:0]                mode;
        logic [LANE_W-1:0]         lane;
        logic [FRAME_W-1:0]        frame;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [GAIN_W-1:0]         gain;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [1:0]                    status;
    } t_out_item;

    typedef struct packed {
        logic sweep;
        logic load_item;
        logic mem_rd;
        logic exec;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic need_div;
        logic div_last;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> sv/woan_dp.sv
// Datapath: config registers, accumulator and weight memories, MAC, divider, output register.
// Depends on woan_pkg; driven by woan_ctrl commands.
module woan_dp import woan_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item
);

    logic [LANES_CFG_W-1:0]  r_lanes;
    logic [FRAMES_CFG_W-1:0] r_frames;
    logic                    r_shared;
    t_in_item                r_item;
    logic [ADDR_W-1:0]       r_sweep;

    logic [ACC_W-1:0]  acc_mem [DEPTH];
    logic [WSUM_W-1:0] w_mem   [DEPTH];
    logic [ACC_W-1:0]  r_acc_rd;
    logic [WSUM_W-1:0] r_w_rd;
    logic signed [PROD_W-1:0] r_prod;

    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_dsh;
    logic [Q_W-1:0]       r_q;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;

    t_out_item r_res;
    t_out_item r_out_item;
    logic      r_out_valid;

    logic [LANES_CFG_W-1:0]  lanes_eff;
    logic [FRAMES_CFG_W-1:0] frames_eff;
    logic                    in_range;
    logic                    skip;
    logic                    upd_w;
    logic [ADDR_W-1:0]       acc_addr;
    logic [ADDR_W-1:0]       w_addr;
    logic signed [PROD_W-1:0] prod_c;
    logic [ACC_W:0]          acc_sum;
    logic                    acc_ovf;
    logic [ACC_W-1:0]        acc_new;
    logic [WSUM_W:0]         w_sum;
    logic                    w_ovf;
    logic [WSUM_W-1:0]       w_new;
    logic                    is_wr_mode;
    logic                    acc_we;
    logic                    w_we;
    logic [ADDR_W-1:0]       acc_wa;
    logic [ADDR_W-1:0]       w_wa;
    logic [ACC_W-1:0]        acc_wd;
    logic [WSUM_W-1:0]       w_wd;
    logic [WSUM_W-1:0]       den;
    logic                    neg_c;
    logic [NUM_W-1:0]        num_c;
    logic                    ge;
    logic [Q_W-1:0]          q_next;
    logic [SAMPLE_BITS:0]    mag;
    logic                    q_sat;
    logic [SAMPLE_BITS-1:0]  q_val;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes  <= LANES_CFG_W'(1);
            r_frames <= FRAMES_CFG_W'(MAX_FRAMES);
            r_shared <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LANES:  r_lanes  <= i_cfg_data[LANES_CFG_W-1:0];
                CFG_FRAMES: r_frames <= i_cfg_data[FRAMES_CFG_W-1:0];
                CFG_SHARED: r_shared <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign lanes_eff  = (r_lanes > LANES_CFG_W'(MAX_LANES)) ? LANES_CFG_W'(MAX_LANES) : r_lanes;
    assign frames_eff = (r_frames > FRAMES_CFG_W'(MAX_FRAMES)) ?
                        FRAMES_CFG_W'(MAX_FRAMES) : r_frames;
    assign in_range   = ({1'b0, r_item.lane} < lanes_eff) && ({1'b0, r_item.frame} < frames_eff);
    assign skip       = (r_item.mode == MODE_NONE) || !in_range;
    assign upd_w      = !r_shared || (r_item.lane == '0);
    assign acc_addr   = {r_item.lane, r_item.frame};
    assign w_addr     = r_shared ? {{LANE_W{1'b0}}, r_item.frame} : acc_addr;
    assign prod_c     = $signed(r_item.sample) * $signed({1'b0, r_item.gain});

    // accumulate with saturation
    assign acc_sum = {r_acc_rd[ACC_W-1], r_acc_rd} +
                     {{(ACC_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
    assign acc_new = !acc_ovf ? acc_sum[ACC_W-1:0] :
                     acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    assign w_sum   = {1'b0, r_w_rd} + (WSUM_W+1)'(r_item.gain);
    assign w_ovf   = w_sum[WSUM_W];
    assign w_new   = w_ovf ? {WSUM_W{1'b1}} : w_sum[WSUM_W-1:0];

    assign is_wr_mode = (r_item.mode == MODE_ACC) || (r_item.mode == MODE_CLR);
    assign acc_we = i_cmd.sweep || (i_cmd.exec && !skip && is_wr_mode);
    assign w_we   = i_cmd.sweep || (i_cmd.exec && !skip && is_wr_mode && upd_w);
    assign acc_wa = i_cmd.sweep ? r_sweep : acc_addr;
    assign w_wa   = i_cmd.sweep ? r_sweep : w_addr;
    assign acc_wd = (!i_cmd.sweep && r_item.mode == MODE_ACC) ? acc_new : '0;
    assign w_wd   = (!i_cmd.sweep && r_item.mode == MODE_ACC) ? w_new : '0;

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_wa] <= acc_wd;
        end
        if (i_cmd.mem_rd) begin
            r_acc_rd <= acc_mem[acc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            w_mem[w_wa] <= w_wd;
        end
        if (i_cmd.mem_rd) begin
            r_w_rd <= w_mem[w_addr];
        end
    end

    // rounded divide: (2|acc| + den) / (2 den), one quotient bit per step
    assign den    = (r_w_rd == '0) ? UNITY_GAIN : r_w_rd;
    assign neg_c  = r_acc_rd[ACC_W-1];
    assign num_c  = {1'b0, (neg_c ? ~r_acc_rd : r_acc_rd), 1'b0} + NUM_W'(den) +
                    (neg_c ? NUM_W'(2) : NUM_W'(0));
    assign ge     = r_rem >= r_dsh;
    assign q_next = {r_q[Q_W-2:0], ge};
    assign mag    = q_next[SAMPLE_BITS:0];
    assign q_sat  = q_next[Q_W-1] || (r_neg ? (mag > NEG_LIMIT) : (mag > POS_LIMIT));
    assign q_val  = q_sat ? (r_neg ? SAMPLE_MIN : SAMPLE_MAX) :
                    (r_neg ? -mag[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.mem_rd) begin
            r_prod <= prod_c;
        end
        if (i_cmd.exec) begin
            r_res.value <= '0;
            r_rem       <= num_c;
            r_dsh       <= NUM_W'({den, 1'b0}) << (Q_W - 1);
            r_q         <= '0;
            r_neg       <= neg_c;
            r_cnt       <= DIV_CNT_W'(Q_W - 1);
            if (skip) begin
                r_res.status <= (r_item.mode == MODE_NONE) ? ST_OK : ST_RANGE;
            end else if (r_item.mode == MODE_ACC) begin
                r_res.status <= (acc_ovf || (upd_w && w_ovf)) ? ST_SAT : ST_OK;
            end else begin
                r_res.status <= ST_OK;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? r_rem - r_dsh : r_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= q_next;
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                r_res.value  <= q_val;
                r_res.status <= q_sat ? ST_SAT : ST_OK;
            end
        end
        if (i_cmd.load_out) begin
            r_out_item <= r_res;
        end
    end

    assign o_sts.sweep_last = r_sweep == ADDR_W'(DEPTH - 1);
    assign o_sts.need_div   = (r_item.mode == MODE_NORM) && !skip;
    assign o_sts.div_last   = r_cnt == '0;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> sv/woan_ctrl.sv
// Controller: sequences reset sweep, memory read, update, divide and output load.
// Depends on woan_pkg and the assertion macro header.
`include "weighted_overlap_add_normalizer_macros.svh"
module woan_ctrl import woan_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_sts.sweep_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = i_sts.need_div ? S_DIV : S_DONE;
            S_DIV:   if (i_sts.div_last) n_state = S_DONE;
            S_DONE:  if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready      = r_state == S_IDLE;
    assign o_cmd.sweep     = r_state == S_CLEAR;
    assign o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.mem_rd    = r_state == S_READ;
    assign o_cmd.exec      = r_state == S_EXEC;
    assign o_cmd.div_step  = r_state == S_DIV;
    assign o_cmd.load_out  = (r_state == S_DONE) && !i_sts.out_busy;

    `WOAN_ASSERT_NXT(a_accept_reads, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_READ)
    `WOAN_ASSERT_NXT(a_div_ends, i_clk, i_rst_n, r_state == S_DIV && i_sts.div_last, r_state == S_DONE)
    `WOAN_ASSERT_IMP(a_sweep_done, i_clk, i_rst_n, r_state == S_IDLE && $past(r_state == S_CLEAR), $past(i_sts.sweep_last))

endmodule

>>> sv/weighted_overlap_add_normalizer.sv
// Accumulate, clear, out-of-range and unused mode pass from accept through the memory read to
// the result register; a normalized read also passes through the one-bit-per-cycle divider.
// One item in flight at a time; a new item is taken only once the last one is loaded for output.
// Reset: synchronous active-low; afterwards a sweep zeroes both memories while
// input ready stays low (configuration writes are taken during it).
module weighted_overlap_add_normalizer import woan_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    woan_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    woan_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
